// ===== rtl/core/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// shared types, constants and float32 helpers for the triangle clip/cull stage
// ----------------------------------------------------------------------------
package tccs_pkg;

	// register file geometry
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 64;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 3;
	localparam int FW        = 32;

	// divider pipeline: one quotient bit per stage, plus prep and round stages
	localparam int DIV_STEPS = 26;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	// winding that counts as front facing
	localparam bit FRONT_FACE_CW = 1'b0;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] ONE_F     = 32'h3F80_0000;
	localparam logic [31:0] INF_F     = 32'h7F80_0000;

	// identity matrix at reset
	localparam logic [REG_W-1:0] MVP_RESET [NUM_REGS] = '{
		64'h0000_0000_3F80_0000, 64'h0000_0000_0000_0000,
		64'h3F80_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_3F80_0000,
		64'h0000_0000_0000_0000, 64'h3F80_0000_0000_0000
	};

	typedef enum logic [1:0] {
		VERDICT_KEEP   = 2'd0,
		VERDICT_W_CLIP = 2'd1,
		VERDICT_Z_CLIP = 2'd2,
		VERDICT_CULLED = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [FW-1:0] v0_x;
		logic [FW-1:0] v0_y;
		logic [FW-1:0] v0_z;
		logic [FW-1:0] v1_x;
		logic [FW-1:0] v1_y;
		logic [FW-1:0] v1_z;
		logic [FW-1:0] v2_x;
		logic [FW-1:0] v2_y;
		logic [FW-1:0] v2_z;
	} tri_in_t;

	typedef struct packed {
		logic [FW-1:0] n0_x;
		logic [FW-1:0] n0_y;
		logic [FW-1:0] n0_z;
		logic [FW-1:0] n1_x;
		logic [FW-1:0] n1_y;
		logic [FW-1:0] n1_z;
		logic [FW-1:0] n2_x;
		logic [FW-1:0] n2_y;
		logic [FW-1:0] n2_z;
		verdict_t      verdict;
	} ndc_out_t;

	// classification
	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// a <= 0, false for nan
	function automatic logic le_zero(input logic [31:0] a);
		return is_zero(a) || (a[31] && !is_nan(a));
	endfunction

	// a < -1 or a > 1, false for nan
	function automatic logic z_out_of_range(input logic [31:0] a);
		return (a[30:0] > ONE_F[30:0]) && !is_nan(a);
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] a);
		return is_nan(a) ? CANON_NAN : a;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// round to nearest even and pack; m[26] is the integer bit at biased exponent e,
	// m[2] guard, m[1:0] round and sticky
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
			input logic [26:0] m);
		logic [26:0] mm;
		logic [26:0] mask;
		logic [11:0] sh;
		logic [9:0]  ebase;
		logic        inc;
		logic [24:0] sum;
		logic [32:0] tmp;
		mm    = m;
		mask  = '0;
		ebase = 10'd0;
		sh    = 12'(12'sd1 - e);
		if (e < 12'sd1) begin
			// subnormal result: shift right keeping a sticky bit
			if (sh >= 12'd27) begin
				mm = {26'd0, |m};
			end else begin
				mask = (27'd1 << sh[4:0]) - 27'd1;
				mm   = (m >> sh[4:0]) | {26'd0, |(m & mask)};
			end
		end else begin
			ebase = e[9:0] - 10'd1;
		end
		inc = mm[2] & (mm[1] | mm[0] | mm[3]);
		sum = {1'b0, mm[26:3]} + {24'd0, inc};
		tmp = {ebase, 23'd0} + {8'd0, sum};
		if (tmp >= {2'b00, INF_F[30:0]}) return {s, INF_F[30:0]};
		return {s, tmp[30:0]};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic              s;
		logic [23:0]       ma, mb;
		logic [7:0]        ea, eb;
		logic [47:0]       p, pn;
		logic [5:0]        lz;
		logic signed [11:0] e;
		s = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
			return CANON_NAN;
		if (is_inf(a) || is_inf(b)) return {s, INF_F[30:0]};
		if (is_zero(a) || is_zero(b)) return {s, 31'd0};
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p  = ma * mb;
		lz = lzc48(p);
		pn = p << lz;
		e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
		return round_pack(s, e, {pn[47:24], pn[23], pn[22], |pn[21:0]});
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [31:0]       x, y;
		logic [7:0]        ex, ey, d;
		logic [23:0]       mx, my;
		logic [26:0]       ys, sm, mask, m;
		logic [27:0]       r;
		logic [4:0]        lz;
		logic signed [11:0] e;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
			return CANON_NAN;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
		// larger magnitude first
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx   = {x[30:23] != 8'd0, x[22:0]};
		my   = {y[30:23] != 8'd0, y[22:0]};
		d    = ex - ey;
		ys   = {my, 3'd0};
		mask = '0;
		// align the smaller operand
		if (d >= 8'd27) begin
			sm = {26'd0, |ys};
		end else begin
			mask = (27'd1 << d[4:0]) - 27'd1;
			sm   = (ys >> d[4:0]) | {26'd0, |(ys & mask)};
		end
		if (x[31] == y[31]) begin
			r = {1'b0, mx, 3'd0} + {1'b0, sm};
			if (r[27]) begin
				m = {r[27:2], r[1] | r[0]};
				e = $signed({4'd0, ex}) + 12'sd1;
			end else begin
				m = r[26:0];
				e = $signed({4'd0, ex});
			end
		end else begin
			r = {1'b0, mx, 3'd0} - {1'b0, sm};
			if (r == 28'd0) return 32'd0;
			lz = lzc27(r[26:0]);
			m  = r[26:0] << lz;
			e  = $signed({4'd0, ex}) - $signed({7'd0, lz});
		end
		return round_pack(x[31], e, m);
	endfunction

	function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
		return fadd(a, {~b[31], b[30:0]});
	endfunction

endpackage

// ===== rtl/core/tccs_fdiv.sv =====
// ----------------------------------------------------------------------------
// tccs_fdiv
// pipelined float32 divider, one quotient bit per stage, round to nearest even
// ----------------------------------------------------------------------------
module tccs_fdiv (
	input  logic                   clk,
	input  logic                   en,
	input  logic [tccs_pkg::FW-1:0] num,
	input  logic [tccs_pkg::FW-1:0] den,
	output logic [tccs_pkg::FW-1:0] quot
);
	import tccs_pkg::*;

	typedef struct packed {
		logic [24:0]        rem;
		logic [23:0]        dvs;
		logic [25:0]        quo;
		logic signed [11:0] ex;
		logic               sgn;
		logic               spc;
		logic [31:0]        spv;
	} div_st_t;

	div_st_t     st_s [DIV_STEPS+1];
	logic [31:0] quot_q;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	// special cases, operand normalization and exponent
	function automatic div_st_t prep(input logic [31:0] a, input logic [31:0] b);
		div_st_t     r;
		logic [23:0] ma, mb, an, bn;
		logic [7:0]  ea, eb;
		logic [4:0]  la, lb;
		r     = '0;
		r.sgn = a[31] ^ b[31];
		ma    = {a[30:23] != 8'd0, a[22:0]};
		mb    = {b[30:23] != 8'd0, b[22:0]};
		ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		la    = lzc24(ma);
		lb    = lzc24(mb);
		an    = ma << la;
		bn    = mb << lb;
		if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b))) begin
			r.spc = 1'b1;
			r.spv = CANON_NAN;
		end else if (is_inf(a) || is_zero(b)) begin
			r.spc = 1'b1;
			r.spv = {r.sgn, INF_F[30:0]};
		end else if (is_zero(a) || is_inf(b)) begin
			r.spc = 1'b1;
			r.spv = {r.sgn, 31'd0};
		end else begin
			r.ex = $signed({4'd0, ea}) - $signed({7'd0, la}) - $signed({4'd0, eb})
				+ $signed({7'd0, lb}) + 12'sd127;
			r.dvs = bn;
			// keep the quotient in [1,2)
			if (an < bn) begin
				r.rem = {an, 1'b0};
				r.ex  = r.ex - 12'sd1;
			end else begin
				r.rem = {1'b0, an};
			end
		end
		return r;
	endfunction

	// one restoring step
	function automatic div_st_t step(input div_st_t s);
		div_st_t     r;
		logic        ge;
		logic [24:0] rn;
		r     = s;
		ge    = s.rem >= {1'b0, s.dvs};
		rn    = ge ? (s.rem - {1'b0, s.dvs}) : s.rem;
		r.rem = {rn[23:0], 1'b0};
		r.quo = {s.quo[24:0], ge};
		return r;
	endfunction

	// divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= prep(num, den);
			for (int k = 1; k <= DIV_STEPS; k++) begin
				st_s[k] <= step(st_s[k-1]);
			end
			quot_q <= st_s[DIV_STEPS].spc ? st_s[DIV_STEPS].spv :
				round_pack(st_s[DIV_STEPS].sgn, st_s[DIV_STEPS].ex,
					{st_s[DIV_STEPS].quo, |st_s[DIV_STEPS].rem});
		end
	end

	assign quot = quot_q;

endmodule

// ===== rtl/core/triangle_clip_cull_stage.sv =====
// ----------------------------------------------------------------------------
// triangle_clip_cull_stage
// float32 vertex transform, w/depth clip reject and back face cull per triangle
// ----------------------------------------------------------------------------
// usage:
//  - vtx channel takes one triangle (three object-space float32 positions) per
//    request; ndc channel returns one result per triangle, in order
//  - result holds the normalized x, y, z of each vertex and a verdict; every
//    coordinate is zero when the triangle is rejected or culled
//  - the 4x4 matrix sits in eight 64-bit registers on the apb port at byte
//    offsets 8*i, to be written by the user only while no triangle is in flight,
//    which the block does not enforce; pready is tied high
//  - a triangle passes the multiply/add tree, the divide pipeline (one quotient
//    bit per stage) and the winding test; throughput is one triangle per cycle
//    unless the receiver stalls, every stage carrying its own valid bit
//  - when the receiver stalls the whole pipeline holds; vtx_ready stays high as
//    long as the output register is empty or being taken
//  - reset clears all valid bits and loads the identity matrix
// ----------------------------------------------------------------------------
module triangle_clip_cull_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vtx_valid,
	output logic                        vtx_ready,
	input  tccs_pkg::tri_in_t           vtx,
	output logic                        ndc_valid,
	input  logic                        ndc_ready,
	output tccs_pkg::ndc_out_t          ndc,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tccs_pkg::ADDR_W-1:0] paddr,
	input  logic [tccs_pkg::REG_W-1:0]  pwdata,
	output logic [tccs_pkg::REG_W-1:0]  prdata,
	output logic                        pready
);
	import tccs_pkg::*;

	logic [REG_W-1:0] mvp_q [NUM_REGS];
	logic [31:0]      mat [4][4];
	logic [31:0]      vin [3][3];
	logic             adv;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [31:0]      prod_s1 [3][4][4];
	logic [31:0]      part_s2 [3][4][2];
	logic [31:0]      clip_s3 [3][4];
	logic             badw_c;

	logic             dv_s [DIV_LAT];
	logic             dw_s [DIV_LAT];
	logic [31:0]      quo [9];

	logic             bw_s4, bz_s4, bw_s5, bz_s5, bw_s6, bz_s6;
	logic [31:0]      n_s4 [9];
	logic [31:0]      n_s5 [9];
	logic [31:0]      n_s6 [9];
	logic [31:0]      pa_s4 [3];
	logic [31:0]      pb_s4 [3];
	logic [31:0]      t_s5 [3];
	logic [31:0]      u_s6, t2_s6;
	logic             badz_c;
	logic [31:0]      area_c;
	logic             cull_c;
	verdict_t         verdict_c;
	ndc_out_t         ndc_s7;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) mvp_q[i] <= MVP_RESET[i];
		end else if (psel && penable && pwrite) begin
			mvp_q[paddr[ADDR_W-1:3]] <= pwdata;
		end
	end

	assign prdata = mvp_q[paddr[ADDR_W-1:3]];
	assign pready = 1'b1;

	// matrix elements and vertex coordinates
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = mvp_q[2*r][31:0];
			mat[r][1] = mvp_q[2*r][63:32];
			mat[r][2] = mvp_q[2*r+1][31:0];
			mat[r][3] = mvp_q[2*r+1][63:32];
		end
		vin[0][0] = vtx.v0_x;
		vin[0][1] = vtx.v0_y;
		vin[0][2] = vtx.v0_z;
		vin[1][0] = vtx.v1_x;
		vin[1][1] = vtx.v1_y;
		vin[1][2] = vtx.v1_z;
		vin[2][0] = vtx.v2_x;
		vin[2][1] = vtx.v2_y;
		vin[2][2] = vtx.v2_z;
	end

	// pipeline advances unless the output register is full and held
	assign adv       = !v_s7 || ndc_ready;
	assign vtx_ready = adv;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) dv_s[i] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1    <= vtx_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			dv_s[0] <= v_s3;
			for (int i = 1; i < DIV_LAT; i++) dv_s[i] <= dv_s[i-1];
			v_s4    <= dv_s[DIV_LAT-1];
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
		end
	end

	// transform: products, pair sums, row sums
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 3; v++) begin
				for (int r = 0; r < 4; r++) begin
					for (int c = 0; c < 3; c++) prod_s1[v][r][c] <= fmul(mat[r][c], vin[v][c]);
					prod_s1[v][r][3] <= mat[r][3];
					part_s2[v][r][0] <= fadd(prod_s1[v][r][0], prod_s1[v][r][1]);
					part_s2[v][r][1] <= fadd(prod_s1[v][r][2], prod_s1[v][r][3]);
					clip_s3[v][r]    <= fadd(part_s2[v][r][0], part_s2[v][r][1]);
				end
			end
		end
	end

	// any clip w not positive
	assign badw_c = le_zero(clip_s3[0][3]) || le_zero(clip_s3[1][3]) || le_zero(clip_s3[2][3]);

	// perspective divide, nine lanes
	for (genvar gv = 0; gv < 3; gv++) begin : g_vert
		for (genvar gc = 0; gc < 3; gc++) begin : g_comp
			tccs_fdiv u_div (
				.clk  (clk),
				.en   (adv),
				.num  (clip_s3[gv][gc]),
				.den  (clip_s3[gv][3]),
				.quot (quo[gv*3+gc])
			);
		end
	end

	// w reject flag rides alongside the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			dw_s[0] <= badw_c;
			for (int i = 1; i < DIV_LAT; i++) dw_s[i] <= dw_s[i-1];
		end
	end

	assign badz_c = z_out_of_range(quo[2]) || z_out_of_range(quo[5]) || z_out_of_range(quo[8]);

	// winding: cross products, differences, two sums
	always_ff @(posedge clk) begin
		if (adv) begin
			bw_s4    <= dw_s[DIV_LAT-1];
			bz_s4    <= badz_c;
			n_s4     <= quo;
			pa_s4[0] <= fmul(quo[0], quo[4]);
			pb_s4[0] <= fmul(quo[3], quo[1]);
			pa_s4[1] <= fmul(quo[3], quo[7]);
			pb_s4[1] <= fmul(quo[6], quo[4]);
			pa_s4[2] <= fmul(quo[6], quo[1]);
			pb_s4[2] <= fmul(quo[0], quo[7]);

			bw_s5 <= bw_s4;
			bz_s5 <= bz_s4;
			n_s5  <= n_s4;
			for (int i = 0; i < 3; i++) t_s5[i] <= fsub(pa_s4[i], pb_s4[i]);

			bw_s6 <= bw_s5;
			bz_s6 <= bz_s5;
			n_s6  <= n_s5;
			u_s6  <= fadd(t_s5[0], t_s5[1]);
			t2_s6 <= t_s5[2];
		end
	end

	// area sign and verdict
	always_comb begin
		area_c = fadd(u_s6, t2_s6);
		if (FRONT_FACE_CW) cull_c = !area_c[31] && !is_nan(area_c) && !is_zero(area_c);
		else               cull_c = area_c[31] && !is_nan(area_c) && !is_zero(area_c);
		if (bw_s6)       verdict_c = VERDICT_W_CLIP;
		else if (bz_s6)  verdict_c = VERDICT_Z_CLIP;
		else if (cull_c) verdict_c = VERDICT_CULLED;
		else             verdict_c = VERDICT_KEEP;
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			ndc_s7.verdict <= verdict_c;
			if (verdict_c == VERDICT_KEEP) begin
				ndc_s7.n0_x <= canon(n_s6[0]);
				ndc_s7.n0_y <= canon(n_s6[1]);
				ndc_s7.n0_z <= canon(n_s6[2]);
				ndc_s7.n1_x <= canon(n_s6[3]);
				ndc_s7.n1_y <= canon(n_s6[4]);
				ndc_s7.n1_z <= canon(n_s6[5]);
				ndc_s7.n2_x <= canon(n_s6[6]);
				ndc_s7.n2_y <= canon(n_s6[7]);
				ndc_s7.n2_z <= canon(n_s6[8]);
			end else begin
				ndc_s7.n0_x <= '0;
				ndc_s7.n0_y <= '0;
				ndc_s7.n0_z <= '0;
				ndc_s7.n1_x <= '0;
				ndc_s7.n1_y <= '0;
				ndc_s7.n1_z <= '0;
				ndc_s7.n2_x <= '0;
				ndc_s7.n2_y <= '0;
				ndc_s7.n2_z <= '0;
			end
		end
	end

	assign ndc_valid = v_s7;
	assign ndc       = ndc_s7;

`ifndef SYNTHESIS
	// a rejected or culled result carries no coordinates
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ndc_valid && (ndc.verdict != VERDICT_KEEP) |->
		((ndc.n0_x | ndc.n0_y | ndc.n0_z | ndc.n1_x | ndc.n1_y | ndc.n1_z |
		  ndc.n2_x | ndc.n2_y | ndc.n2_z) == 32'd0))
		else $error("rejected result has nonzero coordinates");

	// a kept triangle has all depths inside the unit range
	a_kept_depth: assert property (@(posedge clk) disable iff (!arst_n)
		ndc_valid && (ndc.verdict == VERDICT_KEEP) |->
		!z_out_of_range(ndc.n0_z) && !z_out_of_range(ndc.n1_z) && !z_out_of_range(ndc.n2_z))
		else $error("kept result has depth outside range");

	// an empty output register never blocks a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!ndc_valid |-> vtx_ready)
		else $error("request blocked with empty output");

	// a held output keeps the stage before it and the last divider stage frozen
	a_hold_div: assert property (@(posedge clk) disable iff (!arst_n)
		ndc_valid && !ndc_ready |=> $stable(v_s6) && $stable(dv_s[DIV_LAT-1]))
		else $error("pipeline moved while output held");
`endif

endmodule
